/* rtl/tsm_pkg.sv */
// Package for the two-set membership table: payload structs, operation codes and sizes.
// Used by every module of the block; it depends on nothing else.
package tsm_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int ELEM_W        = 32;
   localparam int SIZE_W        = 6;
   localparam int MAX_RUN       = 32;

   typedef enum logic [2:0] {
      MODE_CONTAINS  = 3'd0,
      MODE_ADD       = 3'd1,
      MODE_REMOVE    = 3'd2,
      MODE_LIST      = 3'd3,
      MODE_UNION     = 3'd4,
      MODE_INTERSECT = 3'd5,
      MODE_DIFF      = 3'd6,
      MODE_CLEAR     = 3'd7
   } mode_type;

   typedef struct packed {
      mode_type                  mode;
      logic signed [ELEM_W-1:0]  element_value;
      logic                      set_select;
   } req_type;

   typedef struct packed {
      logic                      answer;
      logic                      full_flag;
      logic                      has_element;
      logic signed [ELEM_W-1:0]  element_out;
      logic                      last;
      logic [SIZE_W-1:0]         result_size;
   } rsp_type;

endpackage

/* rtl/two_set_membership_table_unit.sv */
// Top level of the two-set membership table: operation sequencer and result register.
// Depends on tsm_pkg and instantiates two tsm_store memories.
//
// The block keeps two insertion-ordered sets of distinct 32-bit values.
// One request transfer on req_ is one operation: contains, add, remove,
// clear, or a run (list, union, intersection, difference). Single operations
// return one response transfer on rsp_; a run returns one transfer per
// element with last set on the final one, or one transfer without an
// element when the run is empty. A new request is taken only when the
// previous operation has issued all of its responses.
// Every memory read goes through the registered read port. A lookup reads
// the set one entry at a time, a remove moves each later entry down with a
// read and a write, and a run with an inner lookup does a lookup for each
// outer element. The result register lets the sequencer work while a
// response waits; it stalls only when a further response is ready and the
// receiver has not taken the previous one. Reset empties both sets and drops
// any pending response; the memory contents are left as they are.
module two_set_membership_table_unit #(
   parameter int Depth = tsm_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tsm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tsm_pkg::rsp_type rsp_data
);
   import tsm_pkg::*;

   localparam int CW = $clog2(Depth + 1);
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   typedef struct packed {
      logic              en;
      logic              sel;
      logic [AW-1:0]     addr;
      logic [ELEM_W-1:0] data;
   } wr_type;

   typedef enum logic [3:0] {
      S_IDLE, S_OUT_WAIT, S_OUT_USE, S_IN_WAIT, S_IN_USE, S_DECIDE, S_KEEP,
      S_SHIFT, S_SHIFT_WAIT, S_SHIFT_WR, S_SEND, S_FINISH
   } state_type;

   state_type         state_ff;
   mode_type          mode_ff;
   logic              sel_ff, osel_ff, isel_ff;
   logic              emit_all_ff, want_ff, found_ff, union_ff, pend_v_ff;
   logic [CW-1:0]     o_idx_ff, i_idx_ff;
   logic [CW-1:0]     cnt_ff [2];
   logic [SIZE_W-1:0] n_ff;
   logic [ELEM_W-1:0] elem_ff, pend_ff;
   rsp_type           res_ff, rsp_ff;
   logic              rsp_valid_ff;
   wr_type            wr_ff;
   logic [ELEM_W-1:0] rd_data [2];
   logic              slot_free;

   for (genvar g = 0; g < 2; g++) begin : g_store
      logic [CW-1:0] idx;
      assign idx = (osel_ff == 1'(g)) ? o_idx_ff : i_idx_ff;
      tsm_store #(.Depth(Depth), .AddrWidth(AW)) u_store (
         .clock   (clock),
         .wr_en   (wr_ff.en && (wr_ff.sel == 1'(g))),
         .wr_addr (wr_ff.addr),
         .wr_data (wr_ff.data),
         .rd_addr (idx[AW-1:0]),
         .rd_data (rd_data[g])
      );
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      wr_ff.en <= 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_ff   <= req_data.mode;
               sel_ff    <= req_data.set_select;
               elem_ff   <= req_data.element_value;
               found_ff  <= 1'b0;
               i_idx_ff  <= '0;
               o_idx_ff  <= '0;
               n_ff      <= '0;
               pend_v_ff <= 1'b0;
               union_ff  <= 1'b0;
               case (req_data.mode)
                  MODE_CLEAR: begin
                     cnt_ff[req_data.set_select] <= '0;
                     res_ff   <= '{answer: 1'b1, full_flag: 1'b0, has_element: 1'b0,
                                   element_out: '0, last: 1'b1, result_size: '0};
                     state_ff <= S_SEND;
                  end
                  MODE_CONTAINS, MODE_ADD, MODE_REMOVE: begin
                     isel_ff  <= req_data.set_select;
                     osel_ff  <= !req_data.set_select;
                     state_ff <= S_IN_WAIT;
                  end
                  MODE_LIST: begin
                     osel_ff     <= req_data.set_select;
                     isel_ff     <= !req_data.set_select;
                     emit_all_ff <= 1'b1;
                     state_ff    <= S_OUT_WAIT;
                  end
                  MODE_UNION: begin
                     osel_ff     <= 1'b0;
                     isel_ff     <= 1'b1;
                     emit_all_ff <= 1'b1;
                     union_ff    <= 1'b1;
                     state_ff    <= S_OUT_WAIT;
                  end
                  MODE_INTERSECT: begin
                     osel_ff     <= 1'b1;
                     isel_ff     <= 1'b0;
                     emit_all_ff <= 1'b0;
                     want_ff     <= 1'b1;
                     state_ff    <= S_OUT_WAIT;
                  end
                  default: begin
                     osel_ff     <= req_data.set_select;
                     isel_ff     <= !req_data.set_select;
                     emit_all_ff <= 1'b0;
                     want_ff     <= 1'b0;
                     state_ff    <= S_OUT_WAIT;
                  end
               endcase
            end
         end
         S_OUT_WAIT: begin
            if (o_idx_ff >= cnt_ff[osel_ff] || n_ff == SIZE_W'(MAX_RUN)) begin
               if (union_ff && n_ff != SIZE_W'(MAX_RUN)) begin
                  union_ff    <= 1'b0;
                  osel_ff     <= 1'b1;
                  isel_ff     <= 1'b0;
                  emit_all_ff <= 1'b0;
                  want_ff     <= 1'b0;
                  o_idx_ff    <= '0;
               end else begin
                  state_ff <= S_FINISH;
               end
            end else begin
               state_ff <= S_OUT_USE;
            end
         end
         S_OUT_USE: begin
            elem_ff <= rd_data[osel_ff];
            if (emit_all_ff) begin
               state_ff <= S_KEEP;
            end else begin
               i_idx_ff <= '0;
               found_ff <= 1'b0;
               state_ff <= S_IN_WAIT;
            end
         end
         S_IN_WAIT: begin
            if (i_idx_ff >= cnt_ff[isel_ff]) begin
               state_ff <= S_DECIDE;
            end else begin
               state_ff <= S_IN_USE;
            end
         end
         S_IN_USE: begin
            if (rd_data[isel_ff] == elem_ff) begin
               found_ff <= 1'b1;
               state_ff <= S_DECIDE;
            end else begin
               i_idx_ff <= i_idx_ff + 1'b1;
               state_ff <= S_IN_WAIT;
            end
         end
         S_DECIDE: begin
            res_ff <= '{answer: 1'b0, full_flag: 1'b0, has_element: 1'b0,
                        element_out: '0, last: 1'b1,
                        result_size: SIZE_W'(cnt_ff[isel_ff])};
            case (mode_ff)
               MODE_CONTAINS: begin
                  res_ff.answer <= found_ff;
                  state_ff      <= S_SEND;
               end
               MODE_ADD: begin
                  if (!found_ff && cnt_ff[isel_ff] == CW'(Depth)) begin
                     res_ff.full_flag <= 1'b1;
                  end else if (!found_ff) begin
                     wr_ff <= '{en: 1'b1, sel: isel_ff,
                                addr: cnt_ff[isel_ff][AW-1:0], data: elem_ff};
                     cnt_ff[isel_ff]    <= cnt_ff[isel_ff] + 1'b1;
                     res_ff.answer      <= 1'b1;
                     res_ff.result_size <= SIZE_W'(cnt_ff[isel_ff]) + 1'b1;
                  end
                  state_ff <= S_SEND;
               end
               MODE_REMOVE: begin
                  state_ff <= found_ff ? S_SHIFT : S_SEND;
               end
               default: begin
                  if (found_ff == want_ff) begin
                     state_ff <= S_KEEP;
                  end else begin
                     o_idx_ff <= o_idx_ff + 1'b1;
                     state_ff <= S_OUT_WAIT;
                  end
               end
            endcase
         end
         S_KEEP: begin
            if (!pend_v_ff || slot_free) begin
               if (pend_v_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{answer: 1'b1, full_flag: 1'b0, has_element: 1'b1,
                              element_out: pend_ff, last: 1'b0, result_size: '0};
               end
               pend_ff   <= elem_ff;
               pend_v_ff <= 1'b1;
               n_ff      <= n_ff + 1'b1;
               o_idx_ff  <= o_idx_ff + 1'b1;
               state_ff  <= S_OUT_WAIT;
            end
         end
         S_SHIFT: begin
            if ({1'b0, i_idx_ff} + 1'b1 < {1'b0, cnt_ff[isel_ff]}) begin
               i_idx_ff <= i_idx_ff + 1'b1;
               state_ff <= S_SHIFT_WAIT;
            end else begin
               cnt_ff[isel_ff]    <= cnt_ff[isel_ff] - 1'b1;
               res_ff.answer      <= 1'b1;
               res_ff.result_size <= SIZE_W'(cnt_ff[isel_ff]) - 1'b1;
               state_ff           <= S_SEND;
            end
         end
         S_SHIFT_WAIT: begin
            state_ff <= S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            wr_ff <= '{en: 1'b1, sel: isel_ff,
                       addr: i_idx_ff[AW-1:0] - 1'b1, data: rd_data[isel_ff]};
            state_ff <= S_SHIFT;
         end
         S_SEND: begin
            if (slot_free) begin
               rsp_valid_ff <= 1'b1;
               rsp_ff       <= res_ff;
               state_ff     <= S_IDLE;
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               rsp_valid_ff <= 1'b1;
               if (pend_v_ff) begin
                  rsp_ff <= '{answer: 1'b1, full_flag: 1'b0, has_element: 1'b1,
                              element_out: pend_ff, last: 1'b1, result_size: n_ff};
               end else begin
                  rsp_ff <= '{answer: 1'b1, full_flag: 1'b0, has_element: 1'b0,
                              element_out: '0, last: 1'b1, result_size: '0};
               end
               state_ff <= S_IDLE;
            end
         end
         default: begin
            state_ff <= S_IDLE;
         end
      endcase
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         wr_ff.en     <= 1'b0;
         cnt_ff[0]    <= '0;
         cnt_ff[1]    <= '0;
      end
   end

endmodule

/* rtl/tsm_store.sv */
// One set store: a synchronous memory with one write port and one registered read port.
// Depends on tsm_pkg for the element width.
module tsm_store #(
   parameter int Depth     = tsm_pkg::DEPTH_DEFAULT,
   parameter int AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [AddrWidth-1:0]         wr_addr,
   input  logic [tsm_pkg::ELEM_W-1:0]   wr_data,
   input  logic [AddrWidth-1:0]         rd_addr,
   output logic [tsm_pkg::ELEM_W-1:0]   rd_data
);
   import tsm_pkg::*;

   logic [ELEM_W-1:0] mem [Depth];
   logic [ELEM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/tsm_checker.sv */
// Port-level checks for the two-set membership table, bound to the top level.
// Depends on tsm_pkg and two_set_membership_table_unit.
module tsm_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input tsm_pkg::rsp_type rsp_data
);
   import tsm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed before its transfer");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an operation is still running");

   a_no_elem_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_element |-> rsp_data.last)
      else $error("response without an element is not the final one");

   a_size_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> rsp_data.result_size == '0)
      else $error("size reported before the final response");

   a_full_refused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.full_flag |-> !rsp_data.answer && !rsp_data.has_element)
      else $error("full flag on an accepted operation");

endmodule

bind two_set_membership_table_unit tsm_checker u_tsm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* verif/two_set_membership_table_unit_test.sv */
// Self-checking testbench for two_set_membership_table_unit: directed and random set operations.
// It predicts every response transfer from its own copy of both sets and checks them in order.
// Depends on tsm_pkg and the two_set_membership_table_unit RTL.
module two_set_membership_table_unit_test;
   import tsm_pkg::*;

   localparam int SetDepth = DEPTH_DEFAULT;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   logic [ELEM_W-1:0] set_a [SetDepth];
   logic [ELEM_W-1:0] set_b [SetDepth];
   int                size_a;
   int                size_b;
   rsp_type           pending_rsp[$];
   int                error_count;
   int                send_idle_pct;
   int                recv_idle_pct;
   int                recv_hold;
   logic [ELEM_W-1:0] value_pool [24];

   two_set_membership_table_unit #(.Depth(SetDepth)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #200000000;
      $display("two_set_membership_table_unit_test failed");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      error_count++;
   endtask

   function automatic int find_a(input logic [ELEM_W-1:0] v);
      for (int i = 0; i < size_a; i++) if (set_a[i] == v) return i;
      return -1;
   endfunction

   function automatic int find_b(input logic [ELEM_W-1:0] v);
      for (int i = 0; i < size_b; i++) if (set_b[i] == v) return i;
      return -1;
   endfunction

   function automatic rsp_type make_rsp(input logic ans, input logic full, input logic has,
                                        input logic [ELEM_W-1:0] e, input logic lst,
                                        input int sz);
      rsp_type r;
      r.answer = ans;
      r.full_flag = full;
      r.has_element = has;
      r.element_out = e;
      r.last = lst;
      r.result_size = SIZE_W'(sz);
      return r;
   endfunction

   function automatic void predict_table(input req_type r);
      logic [ELEM_W-1:0] run[$];
      logic [ELEM_W-1:0] v;
      int                pos;
      bit                sel;
      v = r.element_value;
      sel = r.set_select;
      case (r.mode)
         MODE_CONTAINS: begin
            pos = sel ? find_b(v) : find_a(v);
            pending_rsp.push_back(make_rsp(pos >= 0, 0, 0, '0, 1, sel ? size_b : size_a));
            return;
         end
         MODE_ADD: begin
            pos = sel ? find_b(v) : find_a(v);
            if (pos >= 0) begin
               pending_rsp.push_back(make_rsp(0, 0, 0, '0, 1, sel ? size_b : size_a));
            end else if ((sel ? size_b : size_a) >= SetDepth) begin
               pending_rsp.push_back(make_rsp(0, 1, 0, '0, 1, SetDepth));
            end else if (sel) begin
               set_b[size_b] = v;
               size_b++;
               pending_rsp.push_back(make_rsp(1, 0, 0, '0, 1, size_b));
            end else begin
               set_a[size_a] = v;
               size_a++;
               pending_rsp.push_back(make_rsp(1, 0, 0, '0, 1, size_a));
            end
            return;
         end
         MODE_REMOVE: begin
            pos = sel ? find_b(v) : find_a(v);
            if (pos >= 0) begin
               if (sel) begin
                  for (int i = pos; i + 1 < size_b; i++) set_b[i] = set_b[i+1];
                  size_b--;
               end else begin
                  for (int i = pos; i + 1 < size_a; i++) set_a[i] = set_a[i+1];
                  size_a--;
               end
            end
            pending_rsp.push_back(make_rsp(pos >= 0, 0, 0, '0, 1, sel ? size_b : size_a));
            return;
         end
         MODE_CLEAR: begin
            if (sel) size_b = 0;
            else size_a = 0;
            pending_rsp.push_back(make_rsp(1, 0, 0, '0, 1, 0));
            return;
         end
         MODE_LIST: begin
            if (sel) for (int i = 0; i < size_b; i++) run.push_back(set_b[i]);
            else for (int i = 0; i < size_a; i++) run.push_back(set_a[i]);
         end
         MODE_UNION: begin
            for (int i = 0; i < size_a; i++) run.push_back(set_a[i]);
            for (int i = 0; i < size_b; i++)
               if (find_a(set_b[i]) < 0) run.push_back(set_b[i]);
         end
         MODE_INTERSECT: begin
            for (int i = 0; i < size_b; i++)
               if (find_a(set_b[i]) >= 0) run.push_back(set_b[i]);
         end
         default: begin
            if (sel) begin
               for (int i = 0; i < size_b; i++)
                  if (find_a(set_b[i]) < 0) run.push_back(set_b[i]);
            end else begin
               for (int i = 0; i < size_a; i++)
                  if (find_b(set_a[i]) < 0) run.push_back(set_a[i]);
            end
         end
      endcase
      while (run.size() > MAX_RUN) void'(run.pop_back());
      if (run.size() == 0) begin
         pending_rsp.push_back(make_rsp(1, 0, 0, '0, 1, 0));
      end else begin
         for (int i = 0; i < run.size(); i++)
            pending_rsp.push_back(make_rsp(1, 0, 1, run[i], i + 1 == run.size(),
                                           (i + 1 == run.size()) ? run.size() : 0));
      end
   endfunction

   task automatic send_op(input mode_type m, input logic [ELEM_W-1:0] v, input logic sel);
      req_type r;
      r.mode = m;
      r.element_value = v;
      r.set_select = sel;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = r;
      do @(posedge clock); while (!req_ready);
      predict_table(r);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   function automatic logic [ELEM_W-1:0] pick_value();
      if ($urandom_range(0, 9) < 8) return value_pool[$urandom_range(0, 23)];
      return $urandom;
   endfunction

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("response transfer with nothing expected");
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_data.answer !== exp_rsp.answer) report_mismatch("answer");
            if (rsp_data.full_flag !== exp_rsp.full_flag) report_mismatch("full_flag");
            if (rsp_data.has_element !== exp_rsp.has_element) report_mismatch("has_element");
            if (rsp_data.element_out !== exp_rsp.element_out)
               report_mismatch($sformatf("element_out %h expected %h",
                                         rsp_data.element_out, exp_rsp.element_out));
            if (rsp_data.last !== exp_rsp.last) report_mismatch("last");
            if (rsp_data.result_size !== exp_rsp.result_size)
               report_mismatch($sformatf("result_size %0d expected %0d",
                                         rsp_data.result_size, exp_rsp.result_size));
         end
      end
   end

   task automatic test_directed();
      send_op(MODE_CONTAINS, 32'h8000_0000, 0);
      send_op(MODE_LIST, '0, 0);
      send_op(MODE_REMOVE, 32'd5, 1);
      send_op(MODE_ADD, 32'h8000_0000, 0);
      send_op(MODE_ADD, 32'h7fff_ffff, 0);
      send_op(MODE_ADD, 32'hffff_ffff, 0);
      send_op(MODE_ADD, 32'h7fff_ffff, 0);
      send_op(MODE_CONTAINS, 32'hffff_ffff, 0);
      for (int i = 0; i < SetDepth - 3; i++) send_op(MODE_ADD, 32'(i * 7), 0);
      send_op(MODE_ADD, 32'd1234, 0);
      send_op(MODE_ADD, 32'h7fff_ffff, 1);
      send_op(MODE_ADD, 32'd14, 1);
      send_op(MODE_ADD, 32'd999, 1);
      send_op(MODE_UNION, '0, 0);
      send_op(MODE_INTERSECT, '0, 1);
      send_op(MODE_DIFF, '0, 0);
      send_op(MODE_DIFF, '0, 1);
      send_op(MODE_REMOVE, 32'h8000_0000, 0);
      send_op(MODE_REMOVE, 32'd14, 0);
      send_op(MODE_REMOVE, 32'd84, 0);
      send_op(MODE_LIST, '0, 0);
      send_op(MODE_CLEAR, '0, 0);
      send_op(MODE_INTERSECT, '0, 0);
      send_op(MODE_ADD, 32'd3, 0);
      send_op(MODE_REMOVE, 32'd3, 0);
      send_op(MODE_CLEAR, '0, 1);
      send_op(MODE_UNION, '0, 0);
      wait_drained();
   endtask

   task automatic test_random(input int count, input int s_pct, input int r_pct);
      int k;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      for (int n = 0; n < count; n++) begin
         k = $urandom_range(0, 99);
         if (k < 40) send_op(MODE_ADD, pick_value(), 1'($urandom));
         else if (k < 55) send_op(MODE_REMOVE, pick_value(), 1'($urandom));
         else if (k < 65) send_op(MODE_CONTAINS, pick_value(), 1'($urandom));
         else if (k < 97) send_op(mode_type'($urandom_range(3, 6)), $urandom, 1'($urandom));
         else send_op(MODE_CLEAR, $urandom, 1'($urandom));
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      @(negedge clock);
      recv_hold = 600;
      for (int n = 0; n < 20; n++)
         send_op(mode_type'($urandom_range(0, 6)), pick_value(), 1'($urandom));
      wait_drained();
   endtask

   initial begin
      error_count = 0;
      size_a = 0;
      size_b = 0;
      recv_hold = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      req_valid = 1'b0;
      req_data = '0;
      reset = 1'b1;
      for (int i = 0; i < 24; i++) value_pool[i] = $urandom;
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7fff_ffff;
      value_pool[2] = '0;
      value_pool[3] = '1;
      repeat (6) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(130, 13, 67);
      test_backpressure();
      test_random(130, 67, 13);
      test_random(130, 0, 0);
      if (error_count == 0) begin
         $display("two_set_membership_table_unit_test passed");
      end else begin
         $display("two_set_membership_table_unit_test failed");
      end
      $finish;
   end
endmodule

/* sim.f */
rtl/tsm_pkg.sv
rtl/tsm_store.sv
rtl/two_set_membership_table_unit.sv
rtl/tsm_checker.sv
verif/two_set_membership_table_unit_test.sv
